FILE: rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Shared widths, state codes and types for the cosine similarity scorer.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int unsigned ElemW  = 16;              // Q1.15 element width
  localparam int unsigned ProdW  = 2 * ElemW;       // one element product
  localparam int unsigned SumW   = 48;              // running sums
  localparam int unsigned WideW  = 2 * SumW;        // product of two sums
  localparam int unsigned FracSh = 30;              // 2^30 scale of dot^2
  localparam int unsigned RootW  = 132;             // root search datapath
  localparam int unsigned CntW   = 6;               // serial step counter

  localparam logic [CntW-1:0] ElemLast = CntW'(ElemW - 1);
  localparam logic [CntW-1:0] SumLast  = CntW'(SumW - 1);

  // Top level states
  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_MUL   = 3'd1;
  localparam logic [2:0] T_ACC   = 3'd2;
  localparam logic [2:0] T_FIN   = 3'd3;
  localparam logic [2:0] T_SCORE = 3'd4;
  localparam logic [2:0] T_OUT   = 3'd5;

  // Score unit states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;

  // Score unit result towards the top level
  typedef struct packed {
    logic             valid;
    logic [ElemW-1:0] mag;    // 0 .. 32768
  } css_res_t;

endpackage

FILE: rtl/cosine_similarity_scorer.sv
// ----------------------------------------------------------------------------
// cosine_similarity_scorer
// Streams element pairs, keeps dot and norm sums, scores the last pair.
// ----------------------------------------------------------------------------
// Each element pair takes the beat, forms the bit-serial products (one
// multiplier bit a cycle) and then accumulates them into the sums.
// A last pair then runs the score unit (the bit-serial L*R and dot^2
// products, then the 16-bit root search) before the score beat is
// offered; a pair with a zero norm skips the score unit and gives a -1.0 beat.
// A finished score waits in the output register while the next vector
// streams in.
module cosine_similarity_scorer
  import css_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ElemW-1:0] in_left_elem,
  input  logic signed [ElemW-1:0] in_right_elem,
  input  logic                    in_last_pair,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ElemW-1:0] out_score,
  output logic                    out_degenerate
);

  logic [2:0]       state_r;
  logic [CntW-1:0]  cnt_r;
  logic [ElemW-1:0] bits_a_r, bits_b_r;
  logic [ProdW-1:0] sh_a_r, sh_b_r, pd_r, pl_r, pr_r;
  logic             neg_r, last_r, dneg_r, deg_r;
  logic [ElemW-1:0] qmag_r;
  logic signed [SumW-1:0] dot_r;
  logic [SumW-1:0]  lsq_r, rsq_r;
  logic             out_valid_r, out_deg_r;
  logic [ElemW-1:0] out_score_r;

  logic [ElemW-1:0] mag_a, mag_b;
  logic signed [SumW+1:0] nd;
  logic [SumW:0]    nl, nr;
  logic [SumW-1:0]  dot_mag;
  logic             slot_free, start;
  logic [ElemW-1:0] score_val;
  css_res_t         res;

  assign mag_a     = in_left_elem[ElemW-1]  ? -in_left_elem  : in_left_elem;
  assign mag_b     = in_right_elem[ElemW-1] ? -in_right_elem : in_right_elem;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == T_IDLE);
  assign start     = (state_r == T_FIN) && (lsq_r != '0) && (rsq_r != '0);
  assign dot_mag   = dot_r[SumW-1] ? SumW'(-dot_r) : SumW'(dot_r);

  // Saturating accumulate
  assign nd = neg_r ? (SumW+2)'(dot_r) - $signed({18'b0, pd_r})
                    : (SumW+2)'(dot_r) + $signed({18'b0, pd_r});
  assign nl = {1'b0, lsq_r} + (SumW+1)'(pl_r);
  assign nr = {1'b0, rsq_r} + (SumW+1)'(pr_r);

  // Sign and saturate the magnitude
  assign score_val = dneg_r ? -qmag_r
                   : (qmag_r[ElemW-1] ? {1'b0, {(ElemW-1){1'b1}}} : qmag_r);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      dot_r       <= '0;
      lsq_r       <= '0;
      rsq_r       <= '0;
    end else begin
      // Raise the beat when a score is loaded, drop it once taken
      if (state_r == T_OUT && slot_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        T_IDLE: if (in_valid) state_r <= T_MUL;
        T_MUL:  if (cnt_r == ElemLast) state_r <= T_ACC;
        T_ACC: begin
          if (nd > $signed({3'b000, {(SumW-1){1'b1}}}))
            dot_r <= {1'b0, {(SumW-1){1'b1}}};
          else if (nd < $signed({3'b111, (SumW-1)'(0)}))
            dot_r <= {1'b1, (SumW-1)'(0)};
          else
            dot_r <= SumW'(nd);
          lsq_r   <= nl[SumW] ? '1 : nl[SumW-1:0];
          rsq_r   <= nr[SumW] ? '1 : nr[SumW-1:0];
          state_r <= last_r ? T_FIN : T_IDLE;
        end
        T_FIN: state_r <= start ? T_SCORE : T_OUT;
        T_SCORE: if (res.valid) state_r <= T_OUT;
        T_OUT: begin
          if (slot_free) begin
            dot_r       <= '0;
            lsq_r       <= '0;
            rsq_r       <= '0;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      T_IDLE: begin
        cnt_r    <= '0;
        bits_a_r <= mag_a;
        bits_b_r <= mag_b;
        sh_a_r   <= ProdW'(mag_a);
        sh_b_r   <= ProdW'(mag_b);
        pd_r     <= '0;
        pl_r     <= '0;
        pr_r     <= '0;
        neg_r    <= in_left_elem[ElemW-1] ^ in_right_elem[ElemW-1];
        last_r   <= in_last_pair;
      end
      T_MUL: begin
        // one multiplier bit per cycle for all three products
        if (bits_b_r[0]) begin
          pd_r <= pd_r + sh_a_r;
          pr_r <= pr_r + sh_b_r;
        end
        if (bits_a_r[0]) pl_r <= pl_r + sh_a_r;
        bits_a_r <= bits_a_r >> 1;
        bits_b_r <= bits_b_r >> 1;
        sh_a_r   <= sh_a_r << 1;
        sh_b_r   <= sh_b_r << 1;
        cnt_r    <= cnt_r + 1'b1;
      end
      T_FIN: begin
        deg_r  <= !start;
        dneg_r <= dot_r[SumW-1];
      end
      T_SCORE: if (res.valid) qmag_r <= res.mag;
      T_OUT: begin
        if (slot_free) begin
          out_deg_r   <= deg_r;
          out_score_r <= deg_r ? {1'b1, (ElemW-1)'(0)} : score_val;
        end
      end
      default: ;
    endcase
  end

  css_score u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .dot_mag (dot_mag),
    .l_sum   (lsq_r),
    .r_sum   (rsq_r),
    .res     (res)
  );

  assign out_valid      = out_valid_r;
  assign out_score      = out_score_r;
  assign out_degenerate = out_deg_r;

  // A degenerate beat always carries -1.0
  a_deg_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_deg_r |-> out_score_r == {1'b1, (ElemW-1)'(0)})
    else $error("degenerate beat without -1.0 score");

  // One pair at a time
  a_one_pair: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second pair taken while busy");

  // Score unit answers only while awaited
  a_res_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> state_r == T_SCORE)
    else $error("score result outside wait state");

  // Sums are clear once a score beat is loaded
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_OUT && slot_free |=> lsq_r == '0 && rsq_r == '0)
    else $error("sums not cleared after score");

endmodule

FILE: rtl/css_score.sv
// ----------------------------------------------------------------------------
// css_score
// Bit-serial score unit: forms L*R and dot^2 one multiplier bit per cycle,
// then finds the largest q with q^2*L*R <= dot^2*2^30, one bit of q per pass.
// ----------------------------------------------------------------------------
module css_score
  import css_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SumW-1:0] dot_mag,
  input  logic [SumW-1:0] l_sum,
  input  logic [SumW-1:0] r_sum,
  output css_res_t        res
);

  logic [2:0]       state_r;
  logic [CntW-1:0]  cnt_r;
  logic [SumW-1:0]  mplr_p_r, mplr_d_r;
  logic [WideW-1:0] mcnd_p_r, mcnd_d_r, p_r, d_r;
  logic [RootW-1:0] a_r, u_r, s_r, t_r;
  logic [ElemW-1:0] qbit_r, q_r;
  logic             done_r;

  logic [RootW-1:0] d_full, u_acc;

  assign d_full = RootW'({d_r, FracSh'(0)});
  assign u_acc  = (t_r <= d_full) ? u_r + (a_r << 1) : u_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: if (start) state_r <= S_MUL;
        S_MUL:  if (cnt_r == SumLast) state_r <= S_INIT;
        S_INIT: state_r <= S_ADD;
        S_ADD:  state_r <= S_CMP;
        S_CMP: begin
          if (qbit_r[0]) begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end else begin
            state_r <= S_ADD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cnt_r    <= '0;
        mplr_p_r <= r_sum;
        mcnd_p_r <= WideW'(l_sum);
        mplr_d_r <= dot_mag;
        mcnd_d_r <= WideW'(dot_mag);
        p_r      <= '0;
        d_r      <= '0;
      end
      S_MUL: begin
        // add shifted multiplicand where the multiplier bit is set
        if (mplr_p_r[0]) p_r <= p_r + mcnd_p_r;
        if (mplr_d_r[0]) d_r <= d_r + mcnd_d_r;
        mplr_p_r <= mplr_p_r >> 1;
        mplr_d_r <= mplr_d_r >> 1;
        mcnd_p_r <= mcnd_p_r << 1;
        mcnd_d_r <= mcnd_d_r << 1;
        cnt_r    <= cnt_r + 1'b1;
      end
      S_INIT: begin
        a_r    <= RootW'({p_r, FracSh'(0)});
        u_r    <= '0;
        s_r    <= '0;
        q_r    <= '0;
        qbit_r <= {1'b1, (ElemW-1)'(0)};
      end
      S_ADD: t_r <= s_r + u_r + a_r;
      S_CMP: begin
        // keep the trial bit when its square still fits
        if (t_r <= d_full) begin
          s_r <= t_r;
          q_r <= q_r | qbit_r;
        end
        u_r    <= u_acc >> 1;
        a_r    <= a_r >> 2;
        qbit_r <= qbit_r >> 1;
      end
      default: ;
    endcase
  end

  // Clamp to +1.0
  assign res.valid = done_r;
  assign res.mag   = q_r[ElemW-1] ? {1'b1, (ElemW-1)'(0)} : q_r;

endmodule
